FILE: rtl/fp16_cube_root_macros.svh
// fp16_cube_root_macros.svh: assertion macros used by the cube root rtl
// depends on nothing
`ifndef FP16_CUBE_ROOT_MACROS_SVH
`define FP16_CUBE_ROOT_MACROS_SVH

// property must hold at every edge outside reset
`define CBRT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CBRT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cbrt_pkg.sv
// cbrt_pkg: types and constants for the binary16 cube root pipeline
// depends on nothing
package cbrt_pkg;

    localparam int ROOT_BITS_W = 15;
    localparam int RAD_W       = 45;
    localparam int REM_W       = 46;
    localparam int NUM_CELLS   = 15;

    typedef enum logic [1:0] {
        RM_NEAREST_EVEN = 2'd0,
        RM_TOWARD_ZERO  = 2'd1,
        RM_TOWARD_POS   = 2'd2,
        RM_TOWARD_NEG   = 2'd3
    } round_mode_t;

    // data that rides along with the recurrence
    typedef struct packed {
        logic        special;
        logic [15:0] special_bits;
        logic        invalid;
        logic        sign;
        logic signed [7:0] rexp_base;
    } side_t;

    // recurrence state handed from cell to cell
    typedef struct packed {
        logic [RAD_W-1:0]       radicand;
        logic [ROOT_BITS_W-1:0] root;
        logic [REM_W-1:0]       rem;
        side_t                  side;
    } stage_t;

endpackage

FILE: rtl/cbrt_cell.sv
// cbrt_cell: one root bit of the restoring cube root recurrence
// depends on cbrt_pkg
module cbrt_cell
    import cbrt_pkg::*;
#(
    parameter int BIT_POS = 14
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   advance,
    input  logic   valid_in,
    input  stage_t data_in,
    output logic   valid_out,
    output stage_t data_out
);

    // remainder before this step covers the top 3*(14-BIT_POS) radicand bits
    // test r' = 2r+1: rem*8 + next3 >= 12r^2 + 6r + 1
    localparam int LO = 3 * BIT_POS;

    logic                       valid_reg;
    stage_t                     data_reg;
    stage_t                     data_next;
    logic [REM_W-1:0]           rem_shift;
    logic [REM_W-1:0]           trial;
    logic [REM_W-1:0]           r_ext;
    logic [REM_W-1:0]           r_sq;
    logic [2*ROOT_BITS_W-1:0]   r_sq_w;
    logic [2:0]                 next3;

    assign next3     = data_in.radicand[LO +: 3];
    assign r_ext     = REM_W'(data_in.root);
    assign r_sq_w    = {{ROOT_BITS_W{1'b0}}, data_in.root} * {{ROOT_BITS_W{1'b0}}, data_in.root};
    assign r_sq      = REM_W'(r_sq_w);
    assign rem_shift = {data_in.rem[REM_W-4:0], next3};
    assign trial     = (r_sq << 3) + (r_sq << 2) + (r_ext << 2) + (r_ext << 1) + REM_W'(1);

    always_comb begin
        data_next = data_in;
        if (rem_shift >= trial) begin
            data_next.rem  = rem_shift - trial;
            data_next.root = {data_in.root[ROOT_BITS_W-2:0], 1'b1};
        end else begin
            data_next.rem  = rem_shift;
            data_next.root = {data_in.root[ROOT_BITS_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

FILE: rtl/cbrt_round.sv
// cbrt_round: significand extraction, rounding and packing of the root
// depends on cbrt_pkg
module cbrt_round
    import cbrt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic        valid_in,
    input  stage_t      data_in,
    input  logic [1:0]  rounding_mode,
    output logic        valid_out,
    output logic [15:0] root_bits,
    output logic        inexact,
    output logic        invalid
);

    logic        valid_reg;
    logic [15:0] bits_reg;
    logic        inexact_reg;
    logic        invalid_reg;
    logic [15:0] bits_next;
    logic        inexact_next;
    logic [11:0] mant;
    logic        rnd;
    logic        stk;
    logic        inc;
    logic        top;
    logic signed [7:0] rexp;
    logic [14:0] r;

    always_comb begin
        r    = data_in.root;
        top  = r[14];
        if (top) begin
            mant = {1'b0, r[14:4]};
            rnd  = r[3];
            stk  = (r[2:0] != 3'd0) || (data_in.rem != '0);
            rexp = data_in.side.rexp_base + 8'sd14;
        end else begin
            mant = {1'b0, r[13:3]};
            rnd  = r[2];
            stk  = (r[1:0] != 2'd0) || (data_in.rem != '0);
            rexp = data_in.side.rexp_base + 8'sd13;
        end
        case (round_mode_t'(rounding_mode))
            RM_NEAREST_EVEN: inc = rnd && (stk || mant[0]);
            RM_TOWARD_ZERO:  inc = 1'b0;
            RM_TOWARD_POS:   inc = (rnd || stk) && !data_in.side.sign;
            RM_TOWARD_NEG:   inc = (rnd || stk) && data_in.side.sign;
            default:         inc = 1'b0;
        endcase
        mant = mant + 12'(inc);
        if (mant[11]) begin
            mant = 12'h400;
            rexp = rexp + 8'sd1;
        end
        if (data_in.side.special) begin
            bits_next    = data_in.side.special_bits;
            inexact_next = 1'b0;
        end else begin
            bits_next    = {data_in.side.sign, rexp[4:0], mant[9:0]};
            inexact_next = rnd || stk;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            bits_reg    <= bits_next;
            inexact_reg <= inexact_next;
            invalid_reg <= data_in.side.invalid;
        end
    end

    assign valid_out = valid_reg;
    assign root_bits = bits_reg;
    assign inexact   = inexact_reg;
    assign invalid   = invalid_reg;

endmodule

FILE: rtl/fp16_cube_root.sv
// fp16_cube_root: pipelined correctly rounded binary16 cube root
// depends on cbrt_pkg, cbrt_cell, cbrt_round and fp16_cube_root_macros.svh
//
// channel | ports                              | direction
// input   | s_valid s_ready s_operand_bits     | in
// result  | m_valid m_ready m_root_bits m_*    | out
//
// one transaction per cycle while the result is taken; stages: unpack, 15 root cells, round
// each of the 15 root-bit cells resolves one root bit
// the whole pipe advances when the result register is empty or taken
// reset clears valid bits and rounding mode to nearest even
`include "fp16_cube_root_macros.svh"
module fp16_cube_root
    import cbrt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_operand_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_root_bits,
    output logic        m_inexact,
    output logic        m_invalid
);

    logic [1:0]  mode_reg;
    logic        advance;
    logic        in_valid_reg;
    stage_t      in_reg;
    stage_t      in_next;
    logic        valid_chain [0:NUM_CELLS];
    stage_t      data_chain  [0:NUM_CELLS];

    logic        sgn;
    logic [4:0]  bexp;
    logic [9:0]  frac;
    logic [10:0] m;
    logic signed [7:0] e;
    logic [5:0]  s;
    logic [3:0]  lz;
    logic [7:0]  e_off;
    logic [15:0] e_prod;
    logic [7:0]  e_q;
    logic [1:0]  e_r3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 2'd0;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata;
        end
    end

    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    always_comb begin
        sgn  = s_operand_bits[15];
        bexp = s_operand_bits[14:10];
        frac = s_operand_bits[9:0];
        lz   = 4'd0;
        for (int i = 9; i >= 0; i--) begin
            if (frac[i] && lz == 4'd0) begin
                lz = 4'(10 - i);
            end
        end
        if (bexp != 5'd0) begin
            m = {1'b1, frac};
            e = 8'(signed'({3'b0, bexp})) - 8'sd25;
        end else begin
            m = 11'({frac, 1'b0} << (lz - 4'd1));
            e = -8'sd24 - 8'(signed'({4'b0, lz}));
        end
        // e + 90 lies in 56..95, divide by 3 through a reciprocal multiply
        e_off  = 8'(e + 8'sd90);
        e_prod = 16'(e_off) * 16'd171;
        e_q    = {1'b0, e_prod[15:9]};
        e_r3   = 2'(e_off - 8'(e_q * 8'd3));
        case (e_r3)
            2'd0:    s = 6'd30;
            2'd1:    s = 6'd31;
            default: s = 6'd32;
        endcase
        in_next = '0;
        in_next.radicand = RAD_W'({34'b0, m}) << s;
        in_next.side.sign = sgn;
        // e - s = 3*e_q - 120, so (e - s)/3 + 15 = e_q - 25
        in_next.side.rexp_base = signed'(e_q) - 8'sd25;
        in_next.side.special_bits = s_operand_bits;
        in_next.side.invalid = 1'b0;
        in_next.side.special = 1'b0;
        if (bexp == 5'h1f) begin
            in_next.side.special = 1'b1;
            if (frac != 10'd0) begin
                in_next.side.invalid = !frac[9];
                in_next.side.special_bits = s_operand_bits | 16'h0200;
            end
        end else if (bexp == 5'd0 && frac == 10'd0) begin
            in_next.side.special = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            in_reg <= in_next;
        end
    end

    assign valid_chain[0] = in_valid_reg;
    assign data_chain[0]  = in_reg;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        cbrt_cell #(
            .BIT_POS(NUM_CELLS - 1 - g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .valid_in  (valid_chain[g]),
            .data_in   (data_chain[g]),
            .valid_out (valid_chain[g+1]),
            .data_out  (data_chain[g+1])
        );
    end

    cbrt_round u_round (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .valid_in      (valid_chain[NUM_CELLS]),
        .data_in       (data_chain[NUM_CELLS]),
        .rounding_mode (mode_reg),
        .valid_out     (m_valid),
        .root_bits     (m_root_bits),
        .inexact       (m_inexact),
        .invalid       (m_invalid)
    );

    `CBRT_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_root_bits), "result changed while stalled")
    `CBRT_ASSERT(a_ready_rule, aclk, aresetn, s_ready == (!m_valid || m_ready),
        "input ready does not follow output stall")
    `CBRT_ASSERT(a_inv_inex, aclk, aresetn, !(m_valid && m_invalid && m_inexact),
        "invalid and inexact both set")

endmodule

FILE: tb/sv/testbench.sv
// testbench for fp16_cube_root: directed table then random operands, checked
// against a bit-exact cube root predictor; depends on cbrt_pkg and the rtl
module testbench;
    import cbrt_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_wdata = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [15:0] s_operand_bits = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [15:0] m_root_bits;
    logic        m_inexact;
    logic        m_invalid;

    typedef struct packed {
        logic [15:0] root;
        logic        inexact;
        logic        invalid;
    } root_res_t;

    typedef struct {
        logic [15:0] op;
        logic        known;
        root_res_t   res;
    } stim_row_t;

    round_mode_t rmode = RM_NEAREST_EVEN;
    root_res_t   pending_roots[$];
    int          mismatches = 0;
    bit          hold_recv = 0;
    bit          hold_done = 0;
    bit          stim_done = 0;

    fp16_cube_root dut (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    function automatic logic [63:0] floor_cbrt(logic [63:0] n);
        logic [63:0] r, c;
        r = 0;
        for (int b = 14; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c * c <= n) r = c;
        end
        return r;
    endfunction

    function automatic root_res_t cube_root(logic [15:0] bits, round_mode_t rm);
        root_res_t o;
        logic sign;
        logic [4:0] bexp;
        logic [9:0] frac;
        logic [63:0] m, n, r;
        int e, s, p, sh, rexp;
        logic [11:0] mant;
        logic rnd, stk, inc;
        sign = bits[15];
        bexp = bits[14:10];
        frac = bits[9:0];
        o = '{bits, 1'b0, 1'b0};
        if (bexp == 5'h1f) begin
            if (frac != 0) begin
                o.invalid = !frac[9];
                o.root = bits | 16'h0200;
            end
        end else if (bits[14:0] != 0) begin
            if (bexp != 0) begin
                m = 1024 + frac;
                e = int'(bexp) - 25;
            end else begin
                m = frac;
                e = -24;
                while (m < 1024) begin
                    m = m << 1;
                    e--;
                end
            end
            s = 30 + (e - 30 + 300) % 3;
            n = m << s;
            r = floor_cbrt(n);
            p = r[14] ? 14 : 13;
            sh = p - 10;
            mant = 12'(r >> sh);
            rnd = r[sh-1];
            stk = ((r & ((64'd1 << (sh - 1)) - 1)) != 0) || (r * r * r != n);
            rexp = p + (e - s) / 3 + 15;
            case (rm)
                RM_NEAREST_EVEN: inc = rnd && (stk || mant[0]);
                RM_TOWARD_ZERO:  inc = 0;
                RM_TOWARD_POS:   inc = (rnd || stk) && !sign;
                default:         inc = (rnd || stk) && sign;
            endcase
            mant = mant + inc;
            if (mant == 2048) begin
                mant = 1024;
                rexp++;
            end
            o.inexact = rnd || stk;
            o.root = {sign, 5'(rexp), mant[9:0]};
        end
        return o;
    endfunction

    task automatic send_operand(logic [15:0] op);
        s_valid <= 1;
        s_operand_bits <= op;
        pending_roots.push_back(cube_root(op, rmode));
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) g = 0;
        if (g > 0) s_valid <= 0;
        repeat (g) @(posedge aclk);
    endtask

    task automatic drain_and_config(round_mode_t rm);
        s_valid <= 0;
        while (pending_roots.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_we <= 1;
        cfg_wdata <= rm;
        rmode = rm;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    function automatic logic [15:0] random_operand();
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(0, 9))
            0: v[14:10] = 5'h1f;
            1: v[14:10] = 5'h00;
            2: begin
                v[14:10] = 5'h0f + 5'(3 * $urandom_range(0, 4));
                v[9:0] = 0;
            end
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        stim_row_t rows[$];
        rows = '{
            '{16'h0000, 1, '{16'h0000, 0, 0}},
            '{16'h8000, 1, '{16'h8000, 0, 0}},
            '{16'h7c00, 1, '{16'h7c00, 0, 0}},
            '{16'hfc00, 1, '{16'hfc00, 0, 0}},
            '{16'h7e00, 1, '{16'h7e00, 0, 0}},
            '{16'h7c01, 1, '{16'h7e01, 0, 1}},
            '{16'hfdff, 1, '{16'hffff, 0, 1}},
            '{16'h7fff, 1, '{16'h7fff, 0, 0}},
            '{16'h3c00, 1, '{16'h3c00, 0, 0}},
            '{16'hbc00, 1, '{16'hbc00, 0, 0}},
            '{16'h4800, 1, '{16'h4000, 0, 0}},
            '{16'h0001, 0, '{0, 0, 0}},
            '{16'h03ff, 0, '{0, 0, 0}},
            '{16'h8001, 0, '{0, 0, 0}},
            '{16'h0400, 0, '{0, 0, 0}},
            '{16'h7bff, 0, '{0, 0, 0}},
            '{16'hfbff, 0, '{0, 0, 0}},
            '{16'h4000, 0, '{0, 0, 0}},
            '{16'h0151, 0, '{0, 0, 0}},
            '{16'h018b, 0, '{0, 0, 0}}
        };
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        foreach (rows[i]) begin
            send_operand(rows[i].op);
            if (rows[i].known && pending_roots[$] != rows[i].res) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table mismatch: op %h expected %h, predicted %h",
                             rows[i].op, rows[i].res, pending_roots[$]);
            end
            send_gap();
        end
        for (int k = 0; k < 4; k++) begin
            drain_and_config(round_mode_t'(k));
            foreach (rows[i]) send_operand(rows[i].op);
            for (int j = 0; j < 110; j++) begin
                if (k == 1 && j == 20) hold_recv = 1;
                send_operand(random_operand());
                if (k != 1 || j < 20 || j > 60) send_gap();
            end
        end
        drain_and_config(RM_NEAREST_EVEN);
        stim_done = 1;
    end

    initial begin
        int hold;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold_recv && !hold_done) begin
                m_ready <= 0;
                hold = 0;
                while (hold < 200) begin
                    @(posedge aclk);
                    hold++;
                end
                hold_done = 1;
            end else if ($urandom_range(0, 19) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(5, 40)) @(posedge aclk);
            end else if ($urandom_range(0, 2) == 0) begin
                m_ready <= ($urandom_range(0, 1) == 1);
            end else begin
                m_ready <= 1;
            end
        end
    end

    always @(posedge aclk) begin
        root_res_t want, got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_root_bits, m_inexact, m_invalid};
            if (pending_roots.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction %h", got);
            end else begin
                want = pending_roots.pop_front();
                if (want != got) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected root %h inx %b inv %b, got %h %b %b",
                                 want.root, want.inexact, want.invalid,
                                 got.root, got.inexact, got.invalid);
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && pending_roots.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl
rtl/cbrt_pkg.sv
rtl/cbrt_cell.sv
rtl/cbrt_round.sv
rtl/fp16_cube_root.sv
tb/sv/testbench.sv
